// ----- hw/rtl/chroma_four_tap_interpolator_assert.svh -----
// ----------------------------------------------------------------------------
// Chroma four-tap interpolator assertion macros
// Shared property forms for the concurrent checks in the RTL modules.
// ----------------------------------------------------------------------------
`ifndef CHROMA_FOUR_TAP_INTERPOLATOR_ASSERT_SVH
`define CHROMA_FOUR_TAP_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CFTI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CFTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cfti_pkg.sv -----
// ----------------------------------------------------------------------------
// Chroma four-tap interpolator package
// Field widths, register indexes, queue item type and the filter tap table.
// ----------------------------------------------------------------------------
package cfti_pkg;

  localparam int DimW       = 7;
  localparam int WideW      = DimW + 1;
  localparam int PixW       = 8;
  localparam int SampleW    = 16;
  localparam int FracW      = 3;
  localparam int CfgIdxW    = 2;
  localparam int Banks      = 3;
  localparam int BankW      = 2;
  localparam int HSumW      = 18;
  localparam int VSumW      = 24;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_WIDTH  = 2'd0,
    CFG_BLOCK_HEIGHT = 2'd1,
    CFG_X_FRACTION   = 2'd2,
    CFG_Y_FRACTION   = 2'd3
  } cfg_reg_e;

  typedef logic signed [SampleW-1:0] hval_t;

  // Four horizontal values for one vertical tap sum, plus the end-of-block mark.
  typedef struct packed {
    hval_t v0;
    hval_t v1;
    hval_t v2;
    hval_t hv;
    logic  last;
  } vert_item_t;

  typedef struct packed {
    logic [FracW-1:0] x_frac;
    logic [FracW-1:0] y_frac;
  } frac_t;

  // Taps {c0, c1, c2, c3} of an eighth-sample phase, each 8-bit signed.
  function automatic logic [31:0] taps_of(input logic [FracW-1:0] f);
    logic [31:0] t;
    case (f)
      3'd1:    t = {-8'sd2, 8'sd58, 8'sd10, -8'sd2};
      3'd2:    t = {-8'sd4, 8'sd54, 8'sd16, -8'sd2};
      3'd3:    t = {-8'sd6, 8'sd46, 8'sd28, -8'sd4};
      3'd4:    t = {-8'sd4, 8'sd36, 8'sd36, -8'sd4};
      3'd5:    t = {-8'sd4, 8'sd28, 8'sd46, -8'sd6};
      3'd6:    t = {-8'sd2, 8'sd16, 8'sd54, -8'sd4};
      3'd7:    t = {-8'sd2, 8'sd10, 8'sd58, -8'sd2};
      default: t = {8'sd0, 8'sd64, 8'sd0, 8'sd0};
    endcase
    return t;
  endfunction

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic logic [WideW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                 input logic [WideW-1:0] maxv);
    logic [WideW-1:0] r;
    r = {1'b0, v};
    if (v == '0) r = WideW'(1);
    else if (r > maxv) r = maxv;
    return r;
  endfunction

endpackage

// ----- hw/rtl/chroma_four_tap_interpolator.sv -----
// ----------------------------------------------------------------------------
// Chroma four-tap interpolator
// Throughput: one pixel accepted per cycle unless the queue is full; a WxH
//   block takes (W+3)*(H+3) pixels and yields W*H samples.
// Path: front stage register, queue, vertical sum register, output register.
// Reset: position, pixel window and queue clear at once; registers return to
//   width 8, height 8, both fractions 0. The line store is not cleared.
// ----------------------------------------------------------------------------
module chroma_four_tap_interpolator #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // pixel stream
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [cfti_pkg::PixW-1:0]        pixel_i,
  // sample stream
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [cfti_pkg::SampleW-1:0] sample_o,
  output logic                             last_o,
  // register writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [cfti_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [cfti_pkg::DimW-1:0]        cfg_data_i
);

  logic [cfti_pkg::DimW-1:0]  block_width_q, block_height_q;
  cfti_pkg::frac_t            frac_q;
  logic                       cfg_write, restart;
  logic                       q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  cfti_pkg::vert_item_t       q_in_item, q_out_item;
  logic [cfti_pkg::SampleW-1:0] sample;

  // Register writes are always taken; every write restarts the block position.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_width_q  <= cfti_pkg::DimW'(8);
      block_height_q <= cfti_pkg::DimW'(8);
      frac_q         <= '0;
    end else if (cfg_write) begin
      case (cfti_pkg::cfg_reg_e'(cfg_index_i))
        cfti_pkg::CFG_BLOCK_WIDTH:  block_width_q  <= cfg_data_i;
        cfti_pkg::CFG_BLOCK_HEIGHT: block_height_q <= cfg_data_i;
        cfti_pkg::CFG_X_FRACTION:   frac_q.x_frac  <= cfg_data_i[cfti_pkg::FracW-1:0];
        cfti_pkg::CFG_Y_FRACTION:   frac_q.y_frac  <= cfg_data_i[cfti_pkg::FracW-1:0];
        default: ;
      endcase
    end
  end

  // Every index of the port names a register, so every write restarts.
  assign restart = cfg_write;

  // Front end: position tracking, horizontal filter, line store.
  cfti_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .restart_i      (restart),
    .block_width_i  (block_width_q),
    .block_height_i (block_height_q),
    .x_frac_i       (frac_q.x_frac),
    .pix_valid_i    (in_valid_i),
    .pix_ready_o    (in_ready_o),
    .pixel_i        (pixel_i),
    .q_valid_o      (q_in_valid),
    .q_ready_i      (q_in_ready),
    .q_item_o       (q_in_item)
  );

  // Decouple the front end from output stalls.
  cfti_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_in_valid),
    .push_ready_o (q_in_ready),
    .push_item_i  (q_in_item),
    .pop_valid_o  (q_out_valid),
    .pop_ready_i  (q_out_ready),
    .pop_item_o   (q_out_item)
  );

  // Back end: vertical filter and output register.
  cfti_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frac_i       (frac_q),
    .item_valid_i (q_out_valid),
    .item_ready_o (q_out_ready),
    .item_i       (q_out_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_o     (sample),
    .last_o       (last_o)
  );

  assign sample_o = signed'(sample);

endmodule

// ----- hw/rtl/cfti_front.sv -----
// ----------------------------------------------------------------------------
// Chroma four-tap interpolator front end
// Tracks position, runs the horizontal filter, keeps the three-row line store
// and hands complete vertical operand sets to the queue.
// ----------------------------------------------------------------------------
`include "chroma_four_tap_interpolator_assert.svh"

module cfti_front #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          restart_i,
  input  logic [cfti_pkg::DimW-1:0]     block_width_i,
  input  logic [cfti_pkg::DimW-1:0]     block_height_i,
  input  logic [cfti_pkg::FracW-1:0]    x_frac_i,
  input  logic                          pix_valid_i,
  output logic                          pix_ready_o,
  input  logic [cfti_pkg::PixW-1:0]     pixel_i,
  output logic                          q_valid_o,
  input  logic                          q_ready_i,
  output cfti_pkg::vert_item_t          q_item_o
);

  localparam int CntW = $clog2(MAX_WIDTH + 3);
  localparam int RowW = $clog2(MAX_HEIGHT + 3);
  localparam int XW   = $clog2(MAX_WIDTH);

  logic [CntW-1:0]                col_q, col_d, col_end;
  logic [RowW-1:0]                row_q, row_d, row_end;
  logic [cfti_pkg::BankW-1:0]     rb_q, rb_d;
  logic [cfti_pkg::PixW-1:0]      win_q [3];
  logic                           accept, col_live, produce, at_last;
  logic [XW-1:0]                  x_idx;
  logic signed [cfti_pkg::HSumW-1:0] tk [4];
  logic signed [cfti_pkg::HSumW-1:0] pk [4];
  logic signed [cfti_pkg::HSumW-1:0] hsum;
  logic [31:0]                    taps;
  cfti_pkg::hval_t                hv;
  cfti_pkg::hval_t                rd_q [cfti_pkg::Banks];

  logic                           s1_valid_q, s1_produce_q, s1_last_q, s1_free;
  logic [cfti_pkg::BankW-1:0]     s1_rb_q;
  cfti_pkg::hval_t                s1_hv_q;

  assign col_end = CntW'(cfti_pkg::clamp_dim(block_width_i,
                                             cfti_pkg::WideW'(MAX_WIDTH)) + 8'd2);
  assign row_end = RowW'(cfti_pkg::clamp_dim(block_height_i,
                                             cfti_pkg::WideW'(MAX_HEIGHT)) + 8'd2);

  assign s1_free     = !s1_valid_q || !s1_produce_q || q_ready_i;
  assign pix_ready_o = s1_free;
  assign accept      = pix_valid_i && s1_free;

  assign col_live = col_q >= CntW'(3);
  assign produce  = col_live && (row_q >= RowW'(3));
  assign at_last  = (col_q == col_end) && (row_q == row_end);
  assign x_idx    = col_live ? XW'(col_q - CntW'(3)) : '0;

  // Horizontal tap sum over the window and the arriving pixel.
  assign taps = cfti_pkg::taps_of(x_frac_i);
  always_comb begin
    tk[0] = cfti_pkg::HSumW'(signed'(taps[31:24]));
    tk[1] = cfti_pkg::HSumW'(signed'(taps[23:16]));
    tk[2] = cfti_pkg::HSumW'(signed'(taps[15:8]));
    tk[3] = cfti_pkg::HSumW'(signed'(taps[7:0]));
    pk[0] = cfti_pkg::HSumW'(signed'({1'b0, win_q[0]}));
    pk[1] = cfti_pkg::HSumW'(signed'({1'b0, win_q[1]}));
    pk[2] = cfti_pkg::HSumW'(signed'({1'b0, win_q[2]}));
    pk[3] = cfti_pkg::HSumW'(signed'({1'b0, pixel_i}));
    hsum  = tk[0] * pk[0] + tk[1] * pk[1] + tk[2] * pk[2] + tk[3] * pk[3];
    if (x_frac_i == '0) begin
      hv = {{(cfti_pkg::SampleW - cfti_pkg::PixW){1'b0}}, win_q[1]};
    end else begin
      hv = hsum[cfti_pkg::SampleW-1:0];
    end
  end

  always_comb begin
    col_d = col_q + CntW'(1);
    row_d = row_q;
    rb_d  = rb_q;
    if (col_q == col_end) begin
      col_d = '0;
      if (row_q == row_end) begin
        row_d = '0;
        rb_d  = '0;
      end else begin
        row_d = row_q + RowW'(1);
        rb_d  = (rb_q == 2'd2) ? 2'd0 : rb_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      rb_q     <= '0;
      win_q[0] <= '0;
      win_q[1] <= '0;
      win_q[2] <= '0;
    end else if (restart_i) begin
      col_q    <= '0;
      row_q    <= '0;
      rb_q     <= '0;
      win_q[0] <= '0;
      win_q[1] <= '0;
      win_q[2] <= '0;
    end else if (accept) begin
      col_q    <= col_d;
      row_q    <= row_d;
      rb_q     <= rb_d;
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= pixel_i;
    end
  end

  // One bank per row slot; read-first so the oldest row is seen before overwrite.
  for (genvar b = 0; b < cfti_pkg::Banks; b++) begin : g_bank
    cfti_pkg::hval_t mem [MAX_WIDTH];
    always_ff @(posedge clk_i) begin
      if (accept) begin
        if (col_live && rb_q == cfti_pkg::BankW'(b)) mem[x_idx] <= hv;
        rd_q[b] <= mem[x_idx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_free) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_produce_q <= produce;
      s1_last_q    <= at_last;
      s1_hv_q      <= hv;
      s1_rb_q      <= rb_q;
    end
  end

  // Rotate the banks into oldest, middle and newest row order.
  always_comb begin
    q_item_o.hv   = s1_hv_q;
    q_item_o.last = s1_last_q;
    case (s1_rb_q)
      2'd1: begin
        q_item_o.v0 = rd_q[1];
        q_item_o.v1 = rd_q[2];
        q_item_o.v2 = rd_q[0];
      end
      2'd2: begin
        q_item_o.v0 = rd_q[2];
        q_item_o.v1 = rd_q[0];
        q_item_o.v2 = rd_q[1];
      end
      default: begin
        q_item_o.v0 = rd_q[0];
        q_item_o.v1 = rd_q[1];
        q_item_o.v2 = rd_q[2];
      end
    endcase
  end

  assign q_valid_o = s1_valid_q && s1_produce_q;

  `CFTI_ASSERT_NEXT(a_front_wrap, clk_i, rst_ni,
                    accept && at_last && !restart_i,
                    col_q == '0 && row_q == '0 && rb_q == '0,
                    "position did not wrap after the final pixel")
  `CFTI_ASSERT_NOW(a_front_bank_range, clk_i, rst_ni, 1'b1, rb_q != 2'd3,
                   "row bank index out of range")

endmodule

// ----- hw/rtl/cfti_queue.sv -----
// ----------------------------------------------------------------------------
// Chroma four-tap interpolator queue
// Short first-in first-out buffer between the front end and the vertical filter.
// ----------------------------------------------------------------------------
`include "chroma_four_tap_interpolator_assert.svh"

module cfti_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  cfti_pkg::vert_item_t push_item_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output cfti_pkg::vert_item_t pop_item_o
);

  cfti_pkg::vert_item_t              entry_q [cfti_pkg::QueueDepth];
  logic [cfti_pkg::QPtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [cfti_pkg::QCntW-1:0]        count_q;
  logic                              push, pop;

  assign push_ready_o = count_q != cfti_pkg::QCntW'(cfti_pkg::QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + cfti_pkg::QPtrW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + cfti_pkg::QPtrW'(1);
      if (push && !pop) count_q <= count_q + cfti_pkg::QCntW'(1);
      else if (pop && !push) count_q <= count_q - cfti_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_item_i;
  end

  `CFTI_ASSERT_NEXT(a_queue_fill, clk_i, rst_ni, push && !pop,
                    count_q == $past(count_q) + cfti_pkg::QCntW'(1),
                    "queue fill count did not advance on push")

endmodule

// ----- hw/rtl/cfti_back.sv -----
// ----------------------------------------------------------------------------
// Chroma four-tap interpolator back end
// Vertical tap sum, scaling and the output register.
// ----------------------------------------------------------------------------
`include "chroma_four_tap_interpolator_assert.svh"

module cfti_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfti_pkg::frac_t               frac_i,
  input  logic                          item_valid_i,
  output logic                          item_ready_o,
  input  cfti_pkg::vert_item_t          item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cfti_pkg::SampleW-1:0]  sample_o,
  output logic                          last_o
);

  logic [31:0]                          taps;
  logic signed [cfti_pkg::VSumW-1:0]    vk [4];
  logic signed [cfti_pkg::VSumW-1:0]    vv [4];
  logic signed [cfti_pkg::VSumW-1:0]    vsum, a_sum_q, a_shift;
  cfti_pkg::hval_t                      a_v1_q;
  logic                                 a_valid_q, a_last_q, a_ready;
  logic                                 out_valid_q, out_last_q, o_ready;
  logic [cfti_pkg::SampleW-1:0]         sample_d, sample_q;

  assign taps = cfti_pkg::taps_of(frac_i.y_frac);
  always_comb begin
    vk[0] = cfti_pkg::VSumW'(signed'(taps[31:24]));
    vk[1] = cfti_pkg::VSumW'(signed'(taps[23:16]));
    vk[2] = cfti_pkg::VSumW'(signed'(taps[15:8]));
    vk[3] = cfti_pkg::VSumW'(signed'(taps[7:0]));
    vv[0] = cfti_pkg::VSumW'(signed'(item_i.v0));
    vv[1] = cfti_pkg::VSumW'(signed'(item_i.v1));
    vv[2] = cfti_pkg::VSumW'(signed'(item_i.v2));
    vv[3] = cfti_pkg::VSumW'(signed'(item_i.hv));
    vsum  = vk[0] * vv[0] + vk[1] * vv[1] + vk[2] * vv[2] + vk[3] * vv[3];
  end

  assign o_ready      = !out_valid_q || out_ready_i;
  assign a_ready      = !a_valid_q || o_ready;
  assign item_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= item_valid_i;
      if (o_ready) out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && item_valid_i) begin
      a_sum_q  <= vsum;
      a_v1_q   <= item_i.v1;
      a_last_q <= item_i.last;
    end
    if (o_ready && a_valid_q) begin
      sample_q   <= sample_d;
      out_last_q <= a_last_q;
    end
  end

  // Floor shift by six when both passes scaled up; centre row on integer y.
  assign a_shift = a_sum_q >>> 6;
  always_comb begin
    if (frac_i.y_frac == '0) begin
      if (frac_i.x_frac == '0) sample_d = {a_v1_q[cfti_pkg::SampleW-7:0], 6'b0};
      else                     sample_d = a_v1_q;
    end else if (frac_i.x_frac != '0) begin
      sample_d = a_shift[cfti_pkg::SampleW-1:0];
    end else begin
      sample_d = a_sum_q[cfti_pkg::SampleW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign last_o      = out_last_q;

  `CFTI_ASSERT_NEXT(a_back_hold, clk_i, rst_ni, a_valid_q && !o_ready,
                    a_valid_q && $stable(a_sum_q) && $stable(a_last_q),
                    "vertical sum stage lost its item while stalled")

endmodule
